// ----- rtl/core/bcdclk_pkg.sv -----
// shared types, constants and lookup functions for the bcd clock block
`timescale 1ns / 1ps
`default_nettype none

package bcdclk_pkg;

  localparam int DigitCount = 6;
  localparam int DigitW     = 4;
  localparam int ActionW    = 2;
  localparam int ByteW      = 8;
  localparam int SegW       = 8;
  localparam int DriveW     = 8;
  localparam int CountW     = 3;

  // action codes
  localparam logic [ActionW-1:0] ACT_SECOND  = 2'd0;
  localparam logic [ActionW-1:0] ACT_RX      = 2'd1;
  localparam logic [ActionW-1:0] ACT_REFRESH = 2'd2;
  localparam logic [ActionW-1:0] ACT_NONE    = 2'd3;

  // serial command bytes
  localparam logic [ByteW-1:0] CMD_LOAD    = 8'h78;
  localparam logic [ByteW-1:0] CMD_RESTART = 8'h62;
  localparam logic [ByteW-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [ByteW-1:0] ASCII_NINE  = 8'h39;

  localparam logic [DriveW-1:0] DRIVE_ALL_OFF = 8'hFF;
  localparam logic [CountW-1:0] COUNT_MAX     = 3'd7;
  localparam logic [CountW-1:0] COUNT_FULL    = 3'(DigitCount);
  localparam logic [CountW-1:0] SCAN_LAST     = 3'(DigitCount - 1);

  typedef logic [DigitCount-1:0][DigitW-1:0] digits_t;

  typedef struct packed {
    logic [SegW-1:0]   seg_pattern;
    logic              seg_extra;
    logic [DriveW-1:0] digit_drive;
    logic              echo_valid;
    logic [ByteW-1:0]  echo_byte;
    logic              blink_led;
    logic              time_loaded;
  } out_item_t;

  function automatic logic [SegW-1:0] seg_main(input logic [DigitW-1:0] v);
    logic [SegW-1:0] s;
    unique case (v)
      4'd0:    s = 8'd248;
      4'd1:    s = 8'd72;
      4'd2:    s = 8'd188;
      4'd3:    s = 8'd220;
      4'd4:    s = 8'd76;
      4'd5:    s = 8'd212;
      4'd6:    s = 8'd244;
      4'd7:    s = 8'd200;
      4'd8:    s = 8'd252;
      4'd9:    s = 8'd220;
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic seg_extra_bit(input logic [DigitW-1:0] v);
    logic e;
    unique case (v)
      4'd0, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9: e = 1'b1;
      default:                           e = 1'b0;
    endcase
    return e;
  endfunction

  function automatic logic [DriveW-1:0] digit_select(input logic [CountW-1:0] pos);
    logic [DriveW-1:0] d;
    unique case (pos)
      3'd0:    d = 8'd32;
      3'd1:    d = 8'd1;
      3'd2:    d = 8'd2;
      3'd3:    d = 8'd4;
      3'd4:    d = 8'd8;
      3'd5:    d = 8'd16;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bcdclk_if.sv -----
// valid/ready channel interfaces for the command and result sides
`timescale 1ns / 1ps
`default_nettype none

interface bcdclk_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [bcdclk_pkg::ActionW-1:0]  action;
  logic [bcdclk_pkg::ByteW-1:0]    rx_byte;
  logic                            blank_display;

  modport source (output valid, action, rx_byte, blank_display, input ready);
  modport sink (input valid, action, rx_byte, blank_display, output ready);
endinterface

interface bcdclk_res_if;
  logic                            valid;
  logic                            ready;
  logic [bcdclk_pkg::SegW-1:0]     seg_pattern;
  logic                            seg_extra;
  logic [bcdclk_pkg::DriveW-1:0]   digit_drive;
  logic                            echo_valid;
  logic [bcdclk_pkg::ByteW-1:0]    echo_byte;
  logic                            blink_led;
  logic                            time_loaded;

  modport source (output valid, seg_pattern, seg_extra, digit_drive, echo_valid,
                  echo_byte, blink_led, time_loaded, input ready);
  modport sink (input valid, seg_pattern, seg_extra, digit_drive, echo_valid,
                echo_byte, blink_led, time_loaded, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bcdclk_tick.sv -----
// one-second advance of the six bcd digits with carries and hour wrap
`timescale 1ns / 1ps
`default_nettype none

module bcdclk_tick (
  input  wire bcdclk_pkg::digits_t cur,
  output bcdclk_pkg::digits_t      nxt
);

  always_comb begin
    nxt = cur;
    nxt[5] = cur[5] + 4'd1;
    if (nxt[5] >= 4'd10) begin
      nxt[5] = '0;
      nxt[4] = cur[4] + 4'd1;
      if (nxt[4] >= 4'd6) begin
        nxt[4] = '0;
        nxt[3] = cur[3] + 4'd1;
        if (nxt[3] >= 4'd10) begin
          nxt[3] = '0;
          nxt[2] = cur[2] + 4'd1;
          if (nxt[2] >= 4'd6) begin
            nxt[2] = '0;
            nxt[1] = cur[1] + 4'd1;
            if (nxt[1] >= 4'd10) begin
              nxt[1] = '0;
              nxt[0] = cur[0] + 4'd1;
            end
            // hours of 24 or more wrap to midnight
            if (nxt[0] >= 4'd3 || (nxt[0] == 4'd2 && nxt[1] >= 4'd4)) begin
              nxt[0] = '0;
              nxt[1] = '0;
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bcdclk_obuf.sv -----
// result register with a skid stage so a stalled sink does not block input until the skid entry is full
`timescale 1ns / 1ps
`default_nettype none

module bcdclk_obuf (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        push,
  input  wire bcdclk_pkg::out_item_t item,
  output logic                       room,
  bcdclk_res_if.source               res
);

  logic                  head_valid;
  bcdclk_pkg::out_item_t head;
  logic                  skid_valid;
  bcdclk_pkg::out_item_t skid;

  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!head_valid || res.ready) begin
      if (skid_valid) begin
        head       <= skid;
        head_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        head_valid <= push;
        if (push) begin
          head <= item;
        end
      end
    end else if (push) begin
      // sink stalled: park the new beat
      skid       <= item;
      skid_valid <= 1'b1;
    end
  end

  assign res.valid       = head_valid;
  assign res.seg_pattern = head.seg_pattern;
  assign res.seg_extra   = head.seg_extra;
  assign res.digit_drive = head.digit_drive;
  assign res.echo_valid  = head.echo_valid;
  assign res.echo_byte   = head.echo_byte;
  assign res.blink_led   = head.blink_led;
  assign res.time_loaded = head.time_loaded;

endmodule

`default_nettype wire

// ----- rtl/core/bcd_clock_serial_set_display_mux_unit.sv -----
// top level: bcd time-of-day clock with serial set and multiplexed display
// output: each taken command beat yields one registered result beat
// throughput: one command beat per cycle; the two-entry result buffer keeps
//   taking beats until both entries wait on a stalled sink
// reset (synchronous): time and capture digits zero, counters zero, led off,
//   segments off and all digit enables high, result buffer empty
`timescale 1ns / 1ps
`default_nettype none

module bcd_clock_serial_set_display_mux_unit (
  input wire           clk,
  input wire           rst,
  bcdclk_cmd_if.sink   cmd,
  bcdclk_res_if.source res
);

  localparam int CountW = bcdclk_pkg::CountW;

  logic                          accept;
  logic                          room;

  bcdclk_pkg::digits_t           time_digits, time_digits_next, time_ticked;
  bcdclk_pkg::digits_t           capture_digits, capture_digits_next;
  logic [CountW-1:0]             capture_count, capture_count_next;
  logic [CountW-1:0]             scan_position, scan_position_next;
  logic                          led_level, led_level_next;
  logic [bcdclk_pkg::SegW-1:0]   drive_segments, drive_segments_next;
  logic                          drive_extra, drive_extra_next;
  logic [bcdclk_pkg::DriveW-1:0] drive_digits, drive_digits_next;
  logic [bcdclk_pkg::DigitW-1:0] shown;
  logic                          is_digit;
  bcdclk_pkg::out_item_t         item;

  assign cmd.ready = room;
  assign accept    = cmd.valid && room;

  bcdclk_tick u_tick (
    .cur (time_digits),
    .nxt (time_ticked)
  );

  always_comb begin
    time_digits_next    = time_digits;
    capture_digits_next = capture_digits;
    capture_count_next  = capture_count;
    scan_position_next  = scan_position;
    led_level_next      = led_level;
    drive_segments_next = drive_segments;
    drive_extra_next    = drive_extra;
    drive_digits_next   = drive_digits;
    shown               = '0;
    is_digit            = (cmd.rx_byte >= bcdclk_pkg::ASCII_ZERO)
                          && (cmd.rx_byte <= bcdclk_pkg::ASCII_NINE);
    item.echo_valid     = 1'b0;
    item.echo_byte      = '0;
    item.time_loaded    = 1'b0;

    unique case (cmd.action)
      bcdclk_pkg::ACT_SECOND: begin
        led_level_next   = !led_level;
        time_digits_next = time_ticked;
      end
      bcdclk_pkg::ACT_RX: begin
        item.echo_valid = 1'b1;
        item.echo_byte  = cmd.rx_byte;
        if (capture_count == bcdclk_pkg::COUNT_FULL
            && cmd.rx_byte == bcdclk_pkg::CMD_LOAD) begin
          time_digits_next = capture_digits;
          item.time_loaded = 1'b1;
        end
        if (cmd.rx_byte == bcdclk_pkg::CMD_RESTART) begin
          capture_count_next = '0;
        end else begin
          if (is_digit && capture_count < bcdclk_pkg::COUNT_FULL) begin
            capture_digits_next[capture_count] =
              bcdclk_pkg::DigitW'(cmd.rx_byte - bcdclk_pkg::ASCII_ZERO);
          end
          if (capture_count < bcdclk_pkg::COUNT_MAX) begin
            capture_count_next = capture_count + 3'd1;
          end
        end
      end
      bcdclk_pkg::ACT_REFRESH: begin
        if (cmd.blank_display) begin
          drive_digits_next   = bcdclk_pkg::DRIVE_ALL_OFF;
          drive_segments_next = '0;
          drive_extra_next    = 1'b0;
        end else begin
          scan_position_next  = (scan_position >= bcdclk_pkg::SCAN_LAST)
                                ? '0 : scan_position + 3'd1;
          shown               = time_digits[scan_position_next];
          // out-of-range digits fall to the table default of all off
          drive_segments_next = bcdclk_pkg::seg_main(shown);
          drive_extra_next    = bcdclk_pkg::seg_extra_bit(shown);
          drive_digits_next   = ~bcdclk_pkg::digit_select(scan_position_next);
        end
      end
      bcdclk_pkg::ACT_NONE: begin
      end
      default: begin
      end
    endcase

    item.seg_pattern = drive_segments_next;
    item.seg_extra   = drive_extra_next;
    item.digit_drive = drive_digits_next;
    item.blink_led   = led_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_digits    <= '0;
      capture_digits <= '0;
      capture_count  <= '0;
      scan_position  <= '0;
      led_level      <= 1'b0;
      drive_segments <= '0;
      drive_extra    <= 1'b0;
      drive_digits   <= bcdclk_pkg::DRIVE_ALL_OFF;
    end else if (accept) begin
      time_digits    <= time_digits_next;
      capture_digits <= capture_digits_next;
      capture_count  <= capture_count_next;
      scan_position  <= scan_position_next;
      led_level      <= led_level_next;
      drive_segments <= drive_segments_next;
      drive_extra    <= drive_extra_next;
      drive_digits   <= drive_digits_next;
    end
  end

  bcdclk_obuf u_obuf (
    .clk  (clk),
    .rst  (rst),
    .push (accept),
    .item (item),
    .room (room),
    .res  (res)
  );

endmodule

`default_nettype wire

// ----- tb/bcd_clock_serial_set_display_mux_unit_checker.sv -----
// result checker for the bcd clock: predicts each result beat and compares it
`timescale 1ns / 1ps

module bcd_clock_serial_set_display_mux_unit_checker
  import bcdclk_pkg::*;
(
  input wire          clk,
  input wire          rst,
  bcdclk_cmd_if       cmd,
  bcdclk_res_if       res,
  output int unsigned fail_count,
  output int unsigned pending
);

  // segment lookups indexed by digit value, digit selects by scan position, highest entry first
  localparam logic [9:0][SegW-1:0] SEG_LUT = {8'd220, 8'd252, 8'd200, 8'd244, 8'd212,
                                              8'd76, 8'd220, 8'd188, 8'd72, 8'd248};
  localparam logic [9:0] EXTRA_LUT = 10'b1101110001;
  localparam logic [DigitCount-1:0][DriveW-1:0] SELECT_LUT = {8'd16, 8'd8, 8'd4, 8'd2,
                                                              8'd1, 8'd32};

  logic [DigitW-1:0] clock_now [DigitCount];
  logic [DigitW-1:0] capture_buf [DigitCount];
  logic [CountW-1:0] capture_cnt;
  logic [CountW-1:0] scan_pos;
  logic              led_on;
  logic [SegW-1:0]   shown_seg;
  logic              shown_extra;
  logic [DriveW-1:0] shown_digits;

  out_item_t   display_expect_q [$];
  int unsigned errors;
  int unsigned reported;

  function automatic out_item_t predict_display(input logic [ActionW-1:0] act,
                                                input logic [ByteW-1:0] data,
                                                input logic blank);
    out_item_t o;
    int        hours;
    logic [DigitW-1:0] v;
    o = '0;
    case (act)
      ACT_SECOND: begin
        led_on = ~led_on;
        // ripple only while a digit reaches its limit
        clock_now[5] = clock_now[5] + 4'd1;
        if (clock_now[5] >= 4'd10) begin
          clock_now[5] = '0;
          clock_now[4] = clock_now[4] + 4'd1;
          if (clock_now[4] >= 4'd6) begin
            clock_now[4] = '0;
            clock_now[3] = clock_now[3] + 4'd1;
            if (clock_now[3] >= 4'd10) begin
              clock_now[3] = '0;
              clock_now[2] = clock_now[2] + 4'd1;
              if (clock_now[2] >= 4'd6) begin
                clock_now[2] = '0;
                clock_now[1] = clock_now[1] + 4'd1;
                if (clock_now[1] >= 4'd10) begin
                  clock_now[1] = '0;
                  clock_now[0] = clock_now[0] + 4'd1;
                end
                hours = clock_now[0] * 10 + clock_now[1];
                if (hours >= 24) begin
                  clock_now[0] = '0;
                  clock_now[1] = '0;
                end
              end
            end
          end
        end
      end
      ACT_RX: begin
        o.echo_valid = 1'b1;
        o.echo_byte  = data;
        if (capture_cnt == COUNT_FULL && data == CMD_LOAD) begin
          for (int i = 0; i < DigitCount; i++) clock_now[i] = capture_buf[i];
          o.time_loaded = 1'b1;
        end
        if (data == CMD_RESTART) begin
          capture_cnt = '0;
        end else begin
          if (data >= ASCII_ZERO && data <= ASCII_NINE && capture_cnt < COUNT_FULL)
            capture_buf[capture_cnt] = 4'(data - ASCII_ZERO);
          if (capture_cnt < COUNT_MAX) capture_cnt = capture_cnt + 3'd1;
        end
      end
      ACT_REFRESH: begin
        if (blank) begin
          shown_digits = DRIVE_ALL_OFF;
          shown_seg    = '0;
          shown_extra  = 1'b0;
        end else begin
          scan_pos = (scan_pos >= SCAN_LAST) ? '0 : scan_pos + 3'd1;
          v = clock_now[scan_pos];
          if (v < 4'd10) begin
            shown_seg   = SEG_LUT[v];
            shown_extra = EXTRA_LUT[v];
          end else begin
            shown_seg   = '0;
            shown_extra = 1'b0;
          end
          shown_digits = ~SELECT_LUT[scan_pos];
        end
      end
      default: ;
    endcase
    o.seg_pattern = shown_seg;
    o.seg_extra   = shown_extra;
    o.digit_drive = shown_digits;
    o.blink_led   = led_on;
    return o;
  endfunction

  task automatic flag_field(input string field, input int unsigned want,
                            input int unsigned got);
    if (want != got) begin
      errors++;
      if (reported < 10)
        $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
      reported++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < DigitCount; i++) begin
        clock_now[i]   = '0;
        capture_buf[i] = '0;
      end
      capture_cnt  = '0;
      scan_pos     = '0;
      led_on       = 1'b0;
      shown_seg    = '0;
      shown_extra  = 1'b0;
      shown_digits = DRIVE_ALL_OFF;
      display_expect_q.delete();
      errors   = 0;
      reported = 0;
    end else begin
      // results are registered after their command is taken, so compare before predicting
      if (res.valid && res.ready) begin
        if (display_expect_q.size() == 0) begin
          errors++;
          if (reported < 10) $display("%0t: result beat with nothing expected", $realtime);
          reported++;
        end else begin
          want = display_expect_q.pop_front();
          flag_field("seg_pattern", want.seg_pattern, res.seg_pattern);
          flag_field("seg_extra", want.seg_extra, res.seg_extra);
          flag_field("digit_drive", want.digit_drive, res.digit_drive);
          flag_field("echo_valid", want.echo_valid, res.echo_valid);
          flag_field("echo_byte", want.echo_byte, res.echo_byte);
          flag_field("blink_led", want.blink_led, res.blink_led);
          flag_field("time_loaded", want.time_loaded, res.time_loaded);
        end
      end
      if (cmd.valid && cmd.ready)
        display_expect_q.push_back(predict_display(cmd.action, cmd.rx_byte,
                                                   cmd.blank_display));
    end
    fail_count <= errors;
    pending    <= display_expect_q.size();
  end

endmodule

// ----- tb/bcd_clock_serial_set_display_mux_unit_test.sv -----
// testbench top for the bcd clock: clock, reset, command stimulus and verdict
`timescale 1ns / 1ps

module bcd_clock_serial_set_display_mux_unit_test;
  import bcdclk_pkg::*;

  localparam int RANDOM_BEATS = 1950;
  localparam int HOLD_CYCLES  = 60;

  logic        clk;
  logic        rst;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned beats_sent;
  int unsigned burst_left;
  bit          sink_hold_req;

  bcdclk_cmd_if cmd_ch ();
  bcdclk_res_if res_ch ();

  bcd_clock_serial_set_display_mux_unit uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  bcd_clock_serial_set_display_mux_unit_checker display_check (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("bcd_clock_serial_set_display_mux_unit_test: FAIL");
    $finish;
  end

  // result side: stall pattern changes every so often, plus a requested long hold
  initial begin
    int hold;
    int mode;
    int mode_left;
    int phase;
    hold = 0;
    mode = 0;
    mode_left = 0;
    phase = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      phase++;
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (sink_hold_req && hold == 0) begin
        hold = HOLD_CYCLES;
        sink_hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        res_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       res_ch.ready <= 1'b1;
          1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= (phase % 4 != 3);
        endcase
      end
    end
  end

  task automatic send_cmd(input logic [ActionW-1:0] act, input logic [ByteW-1:0] data,
                          input logic blank);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(15, 40);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    cmd_ch.action        <= act;
    cmd_ch.rx_byte       <= data;
    cmd_ch.blank_display <= blank;
    cmd_ch.valid         <= 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    beats_sent++;
  endtask

  task automatic tick();
    send_cmd(ACT_SECOND, 8'($urandom), 1'($urandom));
  endtask

  task automatic refresh(input logic blank);
    send_cmd(ACT_REFRESH, 8'($urandom), blank);
  endtask

  task automatic rx(input logic [ByteW-1:0] data);
    send_cmd(ACT_RX, data, 1'($urandom));
  endtask

  task automatic drain();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned goal;
    int          pick;
    int          n;
    bit          near_midnight;
    bit          held;
    bit          drained;
    logic [DigitW-1:0] d;
    logic [ByteW-1:0]  b;

    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.action = ACT_NONE;
    cmd_ch.rx_byte = '0;
    cmd_ch.blank_display = 1'b0;
    sink_hold_req = 1'b0;
    beats_sent = 0;
    burst_left = 0;
    held = 1'b0;
    drained = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: scan, blanking, unused action, load at 23:59:59 and midnight wrap
    refresh(1'b0);
    tick();
    refresh(1'b1);
    send_cmd(ACT_NONE, 8'hFF, 1'b1);
    rx(CMD_RESTART);
    rx(ASCII_ZERO + 8'd2);
    rx(ASCII_ZERO + 8'd3);
    rx(ASCII_ZERO + 8'd5);
    rx(ASCII_NINE);
    rx(ASCII_ZERO + 8'd5);
    rx(ASCII_NINE);
    rx(CMD_LOAD);
    tick();
    // count is saturated now, so a second load is refused
    rx(CMD_LOAD);
    rx(8'h00);
    rx(8'hFF);
    repeat (6) refresh(1'b0);
    drain();

    goal = beats_sent + RANDOM_BEATS;
    while (beats_sent < goal) begin
      if (!held && beats_sent > 600) begin
        sink_hold_req = 1'b1;
        held = 1'b1;
      end
      if (!drained && beats_sent > 1200) begin
        drain();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // six-digit set command, mostly after a restart, then let the clock run a while
        near_midnight = $urandom_range(0, 1);
        if ($urandom_range(0, 3) != 0) rx(CMD_RESTART);
        for (int i = 0; i < DigitCount; i++) begin
          if (near_midnight) begin
            case (i)
              0:       d = 4'($urandom_range(0, 2));
              1:       d = $urandom_range(0, 1) ? 4'd9 : 4'd3;
              2, 4:    d = 4'd5;
              3:       d = 4'd9;
              default: d = 4'($urandom_range(0, 9));
            endcase
          end else begin
            d = 4'($urandom_range(0, 9));
          end
          rx(ASCII_ZERO + 8'(d));
          if ($urandom_range(0, 7) == 0) refresh(1'b0);
        end
        rx(CMD_LOAD);
        repeat ($urandom_range(1, 40)) begin
          if ($urandom_range(0, 2) == 0) refresh($urandom_range(0, 7) == 0);
          else tick();
        end
      end else if (pick < 65) begin
        // broken or overlong capture
        if ($urandom_range(0, 1) != 0) rx(CMD_RESTART);
        n = $urandom_range(0, 9);
        repeat (n) begin
          case ($urandom_range(0, 9))
            0, 1:    b = 8'($urandom);
            2:       b = CMD_LOAD;
            3:       b = CMD_RESTART;
            default: b = ASCII_ZERO + 8'($urandom_range(0, 9));
          endcase
          rx(b);
        end
        rx(CMD_LOAD);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 8)) send_cmd(2'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 12)) refresh($urandom_range(0, 5) == 0);
      end else begin
        repeat ($urandom_range(1, 30)) tick();
      end
    end

    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("bcd_clock_serial_set_display_mux_unit_test: PASS");
    end else begin
      $display("bcd_clock_serial_set_display_mux_unit_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/bcdclk_pkg.sv
rtl/core/bcdclk_if.sv
rtl/core/bcdclk_tick.sv
rtl/core/bcdclk_obuf.sv
rtl/core/bcd_clock_serial_set_display_mux_unit.sv
tb/bcd_clock_serial_set_display_mux_unit_checker.sv
tb/bcd_clock_serial_set_display_mux_unit_test.sv
